>>> rtl/pfs_pkg.sv
// Shared types, constants and tables for the potential-field steering block.
package pfs_pkg;

  localparam int SIDE_BEAMS   = 6;
  localparam int CORDIC_STEPS = 14;
  localparam int BEAM_SLOTS   = 2 * SIDE_BEAMS;
  localparam int SLOT_W       = $clog2(BEAM_SLOTS);
  localparam int STEP_W       = $clog2(CORDIC_STEPS + 1);
  localparam int LEFT_FIRST   = 200;
  localparam int RIGHT_FIRST  = 160;
  localparam int BEAM_STEP    = 30;

  // Configuration register indexes
  localparam logic [1:0] REG_MAX_SPEED = 2'd0;
  localparam logic [1:0] REG_ARRIVE    = 2'd1;
  localparam logic [1:0] REG_REACH     = 2'd2;
  localparam logic [1:0] REG_GAIN      = 2'd3;

  // Input word kinds
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_STEER  = 1'b1;

  // CORDIC working widths: 17-bit deltas grow by under 2 bits
  localparam int XY_W = 20;
  localparam int Z_W  = 23;
  localparam logic signed [Z_W-1:0] HALF_PI_Q20 = 23'sd1647099;

  // field fits in +-6*4095 < 2^15; product with 10-bit gain fits 27 bits
  localparam int FIELD_W = 17;
  localparam int PROD_W  = 28;

  typedef struct packed {
    logic start;    // latch a steer word, begin the sequence
    logic cordic;   // one CORDIC iteration
    logic beam;     // accumulate one beam slot
    logic finish;   // form turn rate and result
  } pfs_cmd_t;

  typedef struct packed {
    logic arrived;
    logic cordic_last;
    logic beam_last;
  } pfs_sts_t;

  function automatic logic signed [Z_W-1:0] atan_q20(input logic [4:0] i);
    logic signed [Z_W-1:0] v;
    unique case (i)
      5'd0: v = 23'sd823550;   5'd1: v = 23'sd486170;
      5'd2: v = 23'sd256879;   5'd3: v = 23'sd130396;
      5'd4: v = 23'sd65451;    5'd5: v = 23'sd32757;
      5'd6: v = 23'sd16383;    5'd7: v = 23'sd8192;
      5'd8: v = 23'sd4096;     5'd9: v = 23'sd2048;
      5'd10: v = 23'sd1024;    5'd11: v = 23'sd512;
      5'd12: v = 23'sd256;     5'd13: v = 23'sd128;
      5'd14: v = 23'sd64;      5'd15: v = 23'sd32;
      5'd16: v = 23'sd16;      5'd17: v = 23'sd8;
      5'd18: v = 23'sd4;       5'd19: v = 23'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/pfs_ctrl.sv
// Sequencer for steer words: CORDIC iterations, beam sweep, result hand-off.
module pfs_ctrl import pfs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  logic     in_action,
  output logic     out_tvalid,
  input  logic     out_tready,
  output pfs_cmd_t cmd,
  input  pfs_sts_t sts
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_RUN   = 3'd2;
  localparam logic [2:0] ST_FIN   = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       take;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT);
  assign take       = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (take && in_action == ACT_STEER) begin
          cmd.start = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_nxt = sts.arrived ? ST_FIN : ST_RUN;
      end
      // CORDIC and beam sweep run side by side
      ST_RUN: begin
        cmd.cordic = !sts.cordic_last;
        cmd.beam   = !sts.beam_last;
        if (sts.cordic_last && sts.beam_last) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_OUT;
      end
      ST_OUT: begin
        if (out_tready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/pfs_datapath.sv
// Beam table, arrival test, iterative CORDIC, field sum and turn-rate output.
module pfs_datapath import pfs_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [11:0]         cfg_data,
  input  logic                sample_we,
  input  logic [8:0]          in_beam_index,
  input  logic [15:0]         in_beam_range,
  input  logic signed [15:0]  in_pos_x,
  input  logic signed [15:0]  in_pos_y,
  input  logic signed [14:0]  in_heading,
  input  logic signed [15:0]  in_goal_x,
  input  logic signed [15:0]  in_goal_y,
  input  pfs_cmd_t            cmd,
  output pfs_sts_t            sts,
  output logic                out_arrived,
  output logic [9:0]          out_forward_speed,
  output logic signed [16:0]  out_turn_rate
);

  logic [9:0]  speed_set_r, arrive_r, gain_r;
  logic [11:0] reach_r;
  logic [15:0] beam_r [BEAM_SLOTS];
  logic signed [16:0] last_turn_r;

  logic signed [XY_W-1:0] x_r, y_r;
  logic signed [Z_W-1:0]  z_r;
  logic [STEP_W-1:0]      step_r;
  logic [SLOT_W:0]        slot_r;
  logic signed [FIELD_W-1:0] field_r;
  logic signed [14:0]     head_r;
  logic                   zero_r, arrived_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_set_r <= 10'd307;
      arrive_r    <= 10'd205;
      reach_r     <= 12'd512;
      gain_r      <= 10'd128;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_SPEED: speed_set_r <= cfg_data[9:0];
        REG_ARRIVE:    arrive_r    <= cfg_data[9:0];
        REG_REACH:     reach_r     <= cfg_data;
        REG_GAIN:      gain_r      <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // Beam table: slot k left beam, slot SIDE_BEAMS+k right beam
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < BEAM_SLOTS; k++) beam_r[k] <= 16'hFFFF;
    end else if (sample_we) begin
      for (int k = 0; k < SIDE_BEAMS; k++) begin
        if (32'(in_beam_index) == 32'(LEFT_FIRST + BEAM_STEP * k))
          beam_r[k] <= in_beam_range;
        if (32'(in_beam_index) == 32'(RIGHT_FIRST - BEAM_STEP * k))
          beam_r[SIDE_BEAMS + k] <= in_beam_range;
      end
    end
  end

  // Deltas, squared distance, pre-rotation
  logic signed [16:0] dx, dy;
  logic signed [33:0] dxx, dyy, sq;
  logic [19:0]        r2;
  assign dx  = 17'(in_goal_x) - 17'(in_pos_x);
  assign dy  = 17'(in_goal_y) - 17'(in_pos_y);
  assign dxx = 34'(dx) * 34'(dx);
  assign dyy = 34'(dy) * 34'(dy);
  assign sq  = dxx + dyy;
  assign r2  = 20'(arrive_r) * 20'(arrive_r);

  logic signed [XY_W-1:0] xe, ye;
  assign xe = XY_W'(dx);
  assign ye = XY_W'(dy);

  // One CORDIC iteration
  logic signed [XY_W-1:0] xs, ys;
  logic [4:0]             step5;
  assign step5 = 5'(step_r);
  assign xs    = x_r >>> step_r;
  assign ys    = y_r >>> step_r;

  // Beam contribution of current slot
  logic [SLOT_W-1:0]      slot_ix;
  logic [15:0]            cur;
  logic signed [FIELD_W-1:0] contrib;
  assign slot_ix = slot_r[SLOT_W-1:0];
  assign cur     = beam_r[slot_ix];
  assign contrib = (cur < 16'(reach_r)) ? FIELD_W'(16'(reach_r) - cur) : '0;

  assign sts.arrived     = arrived_r;
  assign sts.cordic_last = (32'(step_r) == CORDIC_STEPS);
  assign sts.beam_last   = (32'(slot_r) == BEAM_SLOTS);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      head_r  <= in_heading;
      zero_r  <= (dx == 0) && (dy == 0);
      arrived_r <= (sq < $signed({14'd0, r2}));
      step_r  <= '0;
      slot_r  <= '0;
      field_r <= '0;
      if (dx < 0) begin
        if (dy >= 0) begin
          x_r <= ye; y_r <= -xe; z_r <= HALF_PI_Q20;
        end else begin
          x_r <= -ye; y_r <= xe; z_r <= -HALF_PI_Q20;
        end
      end else begin
        x_r <= xe; y_r <= ye; z_r <= '0;
      end
    end else begin
      if (cmd.cordic) begin
        if (y_r > 0) begin
          x_r <= x_r + ys; y_r <= y_r - xs; z_r <= z_r + atan_q20(step5);
        end else begin
          x_r <= x_r - ys; y_r <= y_r + xs; z_r <= z_r - atan_q20(step5);
        end
        step_r <= step_r + 1'b1;
      end
      if (cmd.beam) begin
        if (32'(slot_ix) < SIDE_BEAMS) field_r <= field_r + contrib;
        else                           field_r <= field_r - contrib;
        slot_r <= slot_r + 1'b1;
      end
    end
  end

  // Turn rate: bearing - heading - gain*field/16, saturated
  logic signed [Z_W-1:0]    zr;
  logic signed [Z_W-9:0]    bear;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] turn;
  assign zr   = z_r + Z_W'(128);
  assign bear = zero_r ? '0 : zr[Z_W-1:8];
  assign prod = PROD_W'($signed({1'b0, gain_r})) * PROD_W'(field_r);
  assign turn = PROD_W'(bear) - PROD_W'(head_r) - (prod >>> 4);

  logic signed [16:0] sat;
  always_comb begin
    priority if (turn > PROD_W'(65535))   sat = 17'sd65535;
    else if (turn < -PROD_W'(65536))      sat = -17'sd65536;
    else                                  sat = turn[16:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_turn_r <= '0;
    end else if (cmd.finish && !arrived_r) begin
      last_turn_r <= sat;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_arrived       <= arrived_r;
      out_forward_speed <= speed_set_r;
      out_turn_rate     <= arrived_r ? last_turn_r : sat;
    end
  end

endmodule

>>> rtl/potential_field_steering.sv
// Top level of the potential-field steering block.
//
//  channel | ports         | word contents
//  in      | in_t*         | tuser: action; tdata: beam_index, beam_range, pos_x, pos_y,
//          |               |        heading, goal_x, goal_y
//  out     | out_t*        | tdata: arrived, forward_speed, turn_rate
//  cfg     | cfg_we/index  | register writes, no read-back
//
// A sample word is taken while idle and gives no result. The result of a steer
// word is registered after the check and finish states when arrived, otherwise
// after the check, run (CORDIC and beam sweep side by side) and finish states;
// then the result waits until out_tready. in_tready stays low meanwhile.
// Reset (rst_n low, synchronous) loads register defaults and sets every beam to
// maximum range.
module potential_field_steering import pfs_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic         in_tuser,          // action
  input  logic [103:0] in_tdata,          // beam_index, beam_range, pos_x, pos_y,
                                          // heading, goal_x, goal_y
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [31:0]  out_tdata,         // arrived, forward_speed, turn_rate, pad
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [11:0]  cfg_data
);

  pfs_cmd_t cmd;
  pfs_sts_t sts;
  logic arrived;
  logic [9:0] speed;
  logic signed [16:0] turn;

  pfs_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_action(in_tuser),
    .out_tvalid, .out_tready, .cmd, .sts
  );

  pfs_datapath u_dp (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .sample_we(in_tvalid && in_tready && in_tuser == ACT_SAMPLE),
    .in_beam_index(in_tdata[8:0]),
    .in_beam_range(in_tdata[24:9]),
    .in_pos_x($signed(in_tdata[40:25])),
    .in_pos_y($signed(in_tdata[56:41])),
    .in_heading($signed(in_tdata[71:57])),
    .in_goal_x($signed(in_tdata[87:72])),
    .in_goal_y($signed(in_tdata[103:88])),
    .cmd, .sts,
    .out_arrived(arrived), .out_forward_speed(speed), .out_turn_rate(turn)
  );

  assign out_tdata = {4'd0, turn, speed, arrived};

endmodule
